### rtl/core/assert_macros.svh
// assertion macros used by the checker file pisd_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define PISD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define PISD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/core/pisd_pkg.sv
// shared types and constants for the palette image stream decoder
// no dependencies
package pisd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);
    localparam int DIM_BITS      = 16;

    localparam logic [3:0] HDR_TRANSP = 4'd8;
    localparam logic [3:0] HDR_KEY_HI = 4'd9;
    localparam logic [3:0] HDR_KEY_LO = 4'd10;
    localparam logic [3:0] HDR_LAST   = 4'd11;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_DIM_ERR   = 2'd1,
        ST_OUT_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    last;
        logic    alpha_clear;
    } pix_ctl_t;

    typedef struct packed {
        logic                 we;
        logic [PAL_IDX_W-1:0] addr;
        logic [15:0]          data;
    } pal_wr_t;

endpackage

### rtl/core/pisd_palette_ram.sv
// palette store, one write port and one registered read port
// depends on pisd_pkg
module pisd_palette_ram (
    input  logic                           aclk,
    input  pisd_pkg::pal_wr_t              wr,
    input  logic                           rd_en,
    input  logic [pisd_pkg::PAL_IDX_W-1:0] rd_addr,
    output logic [15:0]                    rd_data
);

    logic [15:0] mem [pisd_pkg::PALETTE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/pisd_parser.sv
// byte parser: header fields, palette fill with key search, pixel counters
// depends on pisd_pkg
module pisd_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [7:0]                     data_byte,
    input  logic                           start_of_image,
    output pisd_pkg::pal_wr_t              pal_wr,
    output logic                           rd_en,
    output logic [pisd_pkg::PAL_IDX_W-1:0] rd_addr,
    output pisd_pkg::pix_ctl_t             ctl
);

    localparam int DB = pisd_pkg::DIM_BITS;
    localparam int IW = pisd_pkg::PAL_IDX_W;

    pisd_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [3:0]    hcnt_reg, hcnt_next, hcnt_cur;
    logic [31:0]   w_reg, w_next, w_cur;
    logic [31:0]   h_reg, h_next, h_cur;
    logic          transp_reg, transp_next;
    logic [15:0]   key_reg, key_next;
    logic [7:0]    count_reg, count_next;
    logic [8:0]    fill_reg, fill_next;
    logic [7:0]    pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          found_reg, found_next;
    logic [IW-1:0] key_idx_reg, key_idx_next;
    logic [DB-1:0] col_reg, col_next;
    logic [DB-1:0] row_reg, row_next;

    logic          hdr_done;
    logic          dim_err;
    logic          dims_zero_cur;
    logic          dims_zero_reg;
    logic          fill_last;
    logic          pix_last;
    logic          idx_oor;
    logic [15:0]   entry;

    assign phase_cur = start_of_image ? pisd_pkg::PH_HEADER : phase_reg;
    assign hcnt_cur  = start_of_image ? 4'd0 : hcnt_reg;
    assign w_cur     = start_of_image ? 32'd0 : w_reg;
    assign h_cur     = start_of_image ? 32'd0 : h_reg;

    assign hdr_done      = (hcnt_cur == pisd_pkg::HDR_LAST);
    assign dim_err       = (|w_cur[31:DB]) || (|h_cur[31:DB]);
    assign dims_zero_cur = (w_cur[DB-1:0] == '0) || (h_cur[DB-1:0] == '0);
    assign dims_zero_reg = (w_reg[DB-1:0] == '0) || (h_reg[DB-1:0] == '0);
    assign fill_last     = ((fill_reg + 9'd1) == {1'b0, count_reg});
    assign pix_last      = (col_reg == w_reg[DB-1:0] - DB'(1))
                        && (row_reg == h_reg[DB-1:0] - DB'(1));
    assign idx_oor       = (data_byte >= count_reg)
                        || ({1'b0, data_byte} >= 9'(pisd_pkg::PALETTE_DEPTH));
    assign entry         = {pend_reg, data_byte};

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_cur)
                pisd_pkg::PH_HEADER: begin
                    if (!hdr_done) begin
                        phase_next = pisd_pkg::PH_HEADER;
                    end else if (dim_err) begin
                        phase_next = pisd_pkg::PH_IDLE;
                    end else if (data_byte != 8'd0) begin
                        phase_next = pisd_pkg::PH_PALETTE;
                    end else if (dims_zero_cur) begin
                        phase_next = pisd_pkg::PH_IDLE;
                    end else begin
                        phase_next = pisd_pkg::PH_PIXELS;
                    end
                end
                pisd_pkg::PH_PALETTE: begin
                    if (pend_valid_reg && fill_last) begin
                        phase_next = dims_zero_reg ? pisd_pkg::PH_IDLE : pisd_pkg::PH_PIXELS;
                    end
                end
                pisd_pkg::PH_PIXELS: begin
                    if (pix_last) begin
                        phase_next = pisd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase_next = pisd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        hcnt_next       = hcnt_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        transp_next     = transp_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        found_next      = found_reg;
        key_idx_next    = key_idx_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pal_wr          = '0;
        rd_en           = 1'b0;
        rd_addr         = data_byte[IW-1:0];
        ctl             = '0;
        if (accept) begin
            case (phase_cur)
                pisd_pkg::PH_HEADER: begin
                    hcnt_next = hcnt_cur + 4'd1;
                    w_next    = w_cur;
                    h_next    = h_cur;
                    if (hcnt_cur < 4'd4) begin
                        w_next = {w_cur[23:0], data_byte};
                    end else if (hcnt_cur < pisd_pkg::HDR_TRANSP) begin
                        h_next = {h_cur[23:0], data_byte};
                    end else if (hcnt_cur == pisd_pkg::HDR_TRANSP) begin
                        transp_next = (data_byte != 8'd0);
                    end else if (hcnt_cur == pisd_pkg::HDR_KEY_HI) begin
                        key_next = {data_byte, 8'd0};
                    end else if (hcnt_cur == pisd_pkg::HDR_KEY_LO) begin
                        key_next = {key_reg[15:8], data_byte};
                    end else begin
                        count_next = data_byte;
                    end
                    if (hdr_done) begin
                        fill_next       = '0;
                        pend_valid_next = 1'b0;
                        found_next      = 1'b0;
                        col_next        = '0;
                        row_next        = '0;
                        if (dim_err) begin
                            ctl.valid  = 1'b1;
                            ctl.status = pisd_pkg::ST_DIM_ERR;
                            ctl.last   = 1'b1;
                        end
                    end
                end
                pisd_pkg::PH_PALETTE: begin
                    if (!pend_valid_reg) begin
                        pend_next       = data_byte;
                        pend_valid_next = 1'b1;
                    end else begin
                        pend_valid_next = 1'b0;
                        fill_next       = fill_reg + 9'd1;
                        col_next        = '0;
                        row_next        = '0;
                        if (fill_reg < 9'(pisd_pkg::PALETTE_DEPTH)) begin
                            pal_wr.we   = 1'b1;
                            pal_wr.addr = fill_reg[IW-1:0];
                            pal_wr.data = entry;
                            if (transp_reg && !found_reg && entry == key_reg) begin
                                found_next   = 1'b1;
                                key_idx_next = fill_reg[IW-1:0];
                            end
                        end
                    end
                end
                pisd_pkg::PH_PIXELS: begin
                    if (col_reg == w_reg[DB-1:0] - DB'(1)) begin
                        col_next = '0;
                        row_next = row_reg + DB'(1);
                    end else begin
                        col_next = col_reg + DB'(1);
                    end
                    rd_en     = !idx_oor;
                    ctl.valid = 1'b1;
                    ctl.last  = pix_last;
                    if (idx_oor) begin
                        ctl.status = pisd_pkg::ST_OUT_RANGE;
                    end else begin
                        ctl.status      = pisd_pkg::ST_PIXEL;
                        ctl.alpha_clear = transp_reg && found_reg
                                       && (data_byte == 8'(key_idx_reg));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= pisd_pkg::PH_HEADER;
            hcnt_reg       <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            transp_reg     <= 1'b0;
            key_reg        <= '0;
            count_reg      <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
        end else begin
            phase_reg      <= phase_next;
            hcnt_reg       <= hcnt_next;
            w_reg          <= w_next;
            h_reg          <= h_next;
            transp_reg     <= transp_next;
            key_reg        <= key_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        key_idx_reg <= key_idx_next;
    end

endmodule

### rtl/core/pisd_pixel_out.sv
// lookup stage and output register with stall control
// depends on pisd_pkg
module pisd_pixel_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  pisd_pkg::pix_ctl_t ctl,
    input  logic [15:0]        rd_data,
    output logic               in_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);

    pisd_pkg::pix_ctl_t a_reg;
    logic               a_valid_reg, a_valid_next;
    logic               b_valid_reg, b_valid_next;
    logic               a_adv;
    logic [7:0]         red, green, blue, alpha;

    assign a_adv    = !b_valid_reg || m_tready;
    assign in_ready = !a_valid_reg || a_adv;

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (a_adv) begin
            b_valid_next = a_valid_reg;
            a_valid_next = 1'b0;
        end
        if (accept) begin
            a_valid_next = ctl.valid;
        end
    end

    always_comb begin
        case (a_reg.status)
            pisd_pkg::ST_PIXEL: begin
                red   = {rd_data[11:8], rd_data[11:8]};
                green = {rd_data[7:4], rd_data[7:4]};
                blue  = {rd_data[3:0], rd_data[3:0]};
                alpha = a_reg.alpha_clear ? pisd_pkg::ALPHA_CLEAR : pisd_pkg::ALPHA_OPAQUE;
            end
            pisd_pkg::ST_OUT_RANGE: begin
                red   = 8'd0;
                green = 8'd0;
                blue  = 8'd0;
                alpha = pisd_pkg::ALPHA_OPAQUE;
            end
            default: begin
                red   = 8'd0;
                green = 8'd0;
                blue  = 8'd0;
                alpha = pisd_pkg::ALPHA_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg <= ctl;
        end
        if (a_adv) begin
            m_tdata <= {alpha, blue, green, red};
            m_tlast <= a_reg.last;
            m_tuser <= a_reg.status;
        end
    end

    assign m_tvalid = b_valid_reg;

endmodule

### rtl/core/palette_image_stream_decoder.sv
// Palette image stream decoder.
// Input stream s_*: one byte per word. s_tdata carries the stream byte, s_tuser
// marks the first header byte of an image and restarts parsing. The stream is a
// 12-byte header (width, height big-endian 32 bit, transparency flag, 16-bit key
// color, palette size), then the 16-bit palette entries, then one index per pixel.
// Output stream m_*: one RGBA8888 word per pixel, m_tlast on the final pixel or
// on the single dimension error word, m_tuser the status code.
// Throughput: one input word per cycle while s_tready is high; only pixel words and
// the dimension error word on the last header byte give output. The palette read
// register loads at the edge that takes an index, then the output register unless stalled.
// Reset: synchronous, active low; the parser waits for header byte zero, output
// is empty. The palette memory is not cleared; it is written by each image with a palette.
// Stall: with m_tready low the output word holds, one more result word may enter
// the lookup stage, then s_tready stays low until m_tready returns.
// depends on pisd_pkg, pisd_parser, pisd_palette_ram, pisd_pixel_out
module palette_image_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic [0:0]  s_tuser,   // start_of_image [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // status [1:0]
);

    logic                           accept;
    pisd_pkg::pal_wr_t              pal_wr;
    logic                           rd_en;
    logic [pisd_pkg::PAL_IDX_W-1:0] rd_addr;
    logic [15:0]                    rd_data;
    pisd_pkg::pix_ctl_t             ctl;

    assign accept = s_tvalid && s_tready;

    pisd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_tdata),
        .start_of_image (s_tuser[0]),
        .pal_wr         (pal_wr),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .ctl            (ctl)
    );

    pisd_palette_ram u_ram (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pisd_pixel_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .ctl      (ctl),
        .rd_data  (rd_data),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/pisd_checker.sv
// port-level checks for the palette image stream decoder, bound to the top level
// depends on pisd_pkg and assert_macros.svh
`include "assert_macros.svh"

module pisd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    `PISD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid right after reset")
    `PISD_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
                 "stalled word changed")
    `PISD_ASSERT(a_stall_cause, !s_tready |-> m_tvalid && !m_tready,
                 "input stalled without output stall")
    `PISD_ASSERT(a_dim_err_word,
                 m_tvalid && m_tuser == pisd_pkg::ST_DIM_ERR |-> m_tlast && m_tdata == 32'd0,
                 "bad dimension error word")
    `PISD_ASSERT(a_oor_word,
                 m_tvalid && m_tuser == pisd_pkg::ST_OUT_RANGE |-> m_tdata == 32'hFF00_0000,
                 "bad out of range pixel")

endmodule

bind palette_image_stream_decoder pisd_checker u_pisd_checker (.*);
